// ----- rtl/tlw_pkg.sv -----
`timescale 1ns / 1ps

package tlw_pkg;

   localparam int unsigned PPN_WIDTH  = 20;
   localparam int unsigned ASID_WIDTH = 9;
   localparam int unsigned VPN_WIDTH  = 10;
   localparam int unsigned KIND_WIDTH = 2;
   localparam int unsigned PRIV_WIDTH = 2;
   localparam int unsigned PTE_WIDTH  = 32;
   localparam int unsigned ADDR_WIDTH = 32;

   // Stream payload widths; the tdata widths are padded to whole bytes.
   localparam int unsigned REQ_DATA_WIDTH  = 56;
   localparam int unsigned REQ_USER_WIDTH  = 1;
   localparam int unsigned RSP_DATA_WIDTH  = 96;
   localparam int unsigned RSP_USER_WIDTH  = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 20;

   // Bit positions inside rsp_tuser.
   localparam int unsigned RSP_USER_READ   = 0;
   localparam int unsigned RSP_USER_REFILL = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROOT_PPN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ASID     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MXR      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUM      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MPRV     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MPP      = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIV     = 3'd6;

   localparam logic [PRIV_WIDTH-1:0] PRIV_USER       = 2'd0;
   localparam logic [PRIV_WIDTH-1:0] PRIV_SUPERVISOR = 2'd1;
   localparam logic [PRIV_WIDTH-1:0] PRIV_MACHINE    = 2'd3;

   // Access kinds carried with a miss.
   localparam logic [KIND_WIDTH-1:0] KIND_FETCH    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD     = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_STORE    = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_RESERVED = 2'd3;

   // Request modes carried in req_tuser.
   localparam logic MODE_MISS = 1'b0;
   localparam logic MODE_PTE  = 1'b1;

   // Status bits that the permission check needs.
   typedef struct packed {
      logic                  mxr;
      logic                  sum;
      logic                  mprv;
      logic [PRIV_WIDTH-1:0] mpp;
      logic [PRIV_WIDTH-1:0] priv;
   } perm_cfg_type;

   // Outcome of checking one PTE.
   typedef struct packed {
      logic fault;
      logic mega;
   } perm_result_type;

endpackage

// ----- rtl/tlw_perm_check.sv -----
`timescale 1ns / 1ps

module tlw_perm_check (
   input  logic [tlw_pkg::PTE_WIDTH-1:0]  pte,
   input  logic [tlw_pkg::KIND_WIDTH-1:0] kind,
   input  logic                           level_one,
   input  tlw_pkg::perm_cfg_type          cfg,
   output tlw_pkg::perm_result_type       result
);

   logic v, r, w, x, u, a, d;
   logic leaf, kind_ok, user_fault, misaligned, ad_fault, leaf_fault, fault;

   assign v = pte[0];
   assign r = pte[1];
   assign w = pte[2];
   assign x = pte[3];
   assign u = pte[4];
   assign a = pte[6];
   assign d = pte[7];

   assign leaf = r | x;

   assign kind_ok = ((kind == tlw_pkg::KIND_FETCH) & x)
                  | ((kind == tlw_pkg::KIND_LOAD) & (r | (cfg.mxr & x)))
                  | ((kind == tlw_pkg::KIND_STORE) & w);

   // User pages are off limits to supervisor accesses unless SUM is set, and that
   // includes accesses from any other mode made on behalf of supervisor through MPRV.
   assign user_fault = u & ~cfg.sum
                     & ((cfg.priv == tlw_pkg::PRIV_SUPERVISOR)
                        | (cfg.mprv & (cfg.mpp == tlw_pkg::PRIV_SUPERVISOR)));

   assign misaligned = level_one & (pte[19:10] != '0);
   assign ad_fault   = ~a | ((kind == tlw_pkg::KIND_STORE) & ~d);
   assign leaf_fault = ~kind_ok | user_fault | misaligned | ad_fault;

   assign fault = ~v | (~r & w) | (leaf & leaf_fault);

   assign result.fault = fault;
   assign result.mega  = level_one & leaf & ~fault;

endmodule

// ----- rtl/two_level_page_table_walker_core.sv -----
`timescale 1ns / 1ps

// Channel  Direction  tdata / data fields (low bit first)                    tuser
// req      in         vpn_high[9:0] vpn_low[19:10] access_kind[21:20]       mode
//                     pte_word[53:22], zero pad to 56
// rsp      out        read_address[31:0] refill_pte[63:32] refill_asid[72:64] read_request,
//                     refill_vpn_high[82:73] refill_vpn_low[92:83]           refill_valid
//                     refill_megapage[93] page_fault[94], zero pad to 96
// csr      in         csr_index selects the register, csr_data[19:0] value    -
//
// Every request beat yields exactly one response beat, in the cycle after it is taken.
// A new request is taken every cycle unless req_tready is low; the single output register is the only stage.
// req_tready drops only while a response waits in that register and rsp_tready is low.
// Synchronous reset returns the walker to idle and empties the output register.
// csr_ready is always high.

module two_level_page_table_walker_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // vpn_high, vpn_low, access_kind, pte_word
   input  logic [tlw_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // mode
   input  logic [tlw_pkg::REQ_USER_WIDTH-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // read_address, refill_pte, refill_asid, refill_vpn_high, refill_vpn_low,
   // refill_megapage, page_fault
   output logic [tlw_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   // read_request, refill_valid
   output logic [tlw_pkg::RSP_USER_WIDTH-1:0]    rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tlw_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tlw_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_L1   = 3'b010,
      PHASE_L2   = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in;

   logic [tlw_pkg::PPN_WIDTH-1:0]  root_ppn_ff;
   logic [tlw_pkg::ASID_WIDTH-1:0] asid_ff;
   tlw_pkg::perm_cfg_type          perm_cfg_ff;

   logic [tlw_pkg::VPN_WIDTH-1:0]  vpn_high_ff, vpn_high_in;
   logic [tlw_pkg::VPN_WIDTH-1:0]  vpn_low_ff, vpn_low_in;
   logic [tlw_pkg::KIND_WIDTH-1:0] kind_ff, kind_in;

   logic                                 rsp_valid_ff;
   logic [tlw_pkg::RSP_DATA_WIDTH-1:0]   rsp_data_ff, rsp_data_in;
   logic [tlw_pkg::RSP_USER_WIDTH-1:0]   rsp_user_ff, rsp_user_in;

   logic                           req_accept;
   logic                           mode;
   logic [tlw_pkg::VPN_WIDTH-1:0]  req_vpn_high, req_vpn_low;
   logic [tlw_pkg::KIND_WIDTH-1:0] req_kind;
   logic [tlw_pkg::PTE_WIDTH-1:0]  req_pte;

   tlw_pkg::perm_result_type       check;

   logic                            read_request, refill_valid, refill_mega, page_fault;
   logic [tlw_pkg::ADDR_WIDTH-1:0]  read_address;
   logic [tlw_pkg::PTE_WIDTH-1:0]   refill_pte;
   logic [tlw_pkg::ASID_WIDTH-1:0]  refill_asid;
   logic [tlw_pkg::VPN_WIDTH-1:0]   refill_vpn_high, refill_vpn_low;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign mode         = req_tuser[0];
   assign req_vpn_high = req_tdata[9:0];
   assign req_vpn_low  = req_tdata[19:10];
   assign req_kind     = req_tdata[21:20];
   assign req_pte      = req_tdata[53:22];

   tlw_perm_check u_perm_check (
      .pte       (req_pte),
      .kind      (kind_ff),
      .level_one (phase_ff == PHASE_L1),
      .cfg       (perm_cfg_ff),
      .result    (check)
   );

   always_comb begin
      phase_in        = phase_ff;
      vpn_high_in     = vpn_high_ff;
      vpn_low_in      = vpn_low_ff;
      kind_in         = kind_ff;
      read_request    = 1'b0;
      read_address    = '0;
      refill_valid    = 1'b0;
      refill_pte      = '0;
      refill_asid     = '0;
      refill_vpn_high = '0;
      refill_vpn_low  = '0;
      refill_mega     = 1'b0;
      page_fault      = 1'b0;

      // A miss while a walk is open, or a PTE while idle, gives an all-zero beat.
      if (mode == tlw_pkg::MODE_MISS) begin
         if (phase_ff == PHASE_IDLE) begin
            vpn_high_in  = req_vpn_high;
            vpn_low_in   = req_vpn_low;
            kind_in      = req_kind;
            read_request = 1'b1;
            read_address = {root_ppn_ff, req_vpn_high, 2'b00};
            phase_in     = PHASE_L1;
         end
      end else begin
         case (phase_ff)
            PHASE_L1: begin
               if (check.fault | check.mega) begin
                  refill_valid = 1'b1;
                  refill_mega  = check.mega;
                  page_fault   = check.fault;
                  phase_in     = PHASE_IDLE;
               end else begin
                  // The PPN above bit 29 falls off the 32-bit address.
                  read_request = 1'b1;
                  read_address = {req_pte[29:10], vpn_low_ff, 2'b00};
                  phase_in     = PHASE_L2;
               end
            end
            PHASE_L2: begin
               refill_valid = 1'b1;
               page_fault   = check.fault;
               phase_in     = PHASE_IDLE;
            end
            default: begin
            end
         endcase
         if (refill_valid) begin
            refill_pte      = req_pte;
            refill_asid     = asid_ff;
            refill_vpn_high = vpn_high_ff;
            refill_vpn_low  = vpn_low_ff;
         end
      end

      rsp_data_in = {1'b0, page_fault, refill_mega, refill_vpn_low, refill_vpn_high,
                     refill_asid, refill_pte, read_address};
      rsp_user_in = {refill_valid, read_request};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         rsp_valid_ff <= 1'b0;
         vpn_high_ff  <= '0;
         vpn_low_ff   <= '0;
         kind_ff      <= '0;
      end else begin
         if (req_accept) begin
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
            vpn_high_ff  <= vpn_high_in;
            vpn_low_ff   <= vpn_low_in;
            kind_ff      <= kind_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ppn_ff <= '0;
         asid_ff     <= '0;
         perm_cfg_ff <= '{mxr: 1'b0, sum: 1'b0, mprv: 1'b0, mpp: '0,
                          priv: tlw_pkg::PRIV_MACHINE};
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            tlw_pkg::CSR_ROOT_PPN: root_ppn_ff      <= csr_data[19:0];
            tlw_pkg::CSR_ASID:     asid_ff          <= csr_data[8:0];
            tlw_pkg::CSR_MXR:      perm_cfg_ff.mxr  <= csr_data[0];
            tlw_pkg::CSR_SUM:      perm_cfg_ff.sum  <= csr_data[0];
            tlw_pkg::CSR_MPRV:     perm_cfg_ff.mprv <= csr_data[0];
            tlw_pkg::CSR_MPP:      perm_cfg_ff.mpp  <= csr_data[1:0];
            tlw_pkg::CSR_PRIV:     perm_cfg_ff.priv <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/tlw_checker.sv -----
`timescale 1ns / 1ps

module tlw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tlw_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input logic [tlw_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser
);

   // Every accepted request produces a response beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request beat without a response beat");

   // The walker never stalls its input while the output register is empty.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output register");

   // A beat either issues a read, ends the walk, or is empty: never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[tlw_pkg::RSP_USER_READ]
                       && rsp_tuser[tlw_pkg::RSP_USER_REFILL]))
      else $error("read and refill in one beat");

   // Without a read the address field is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[tlw_pkg::RSP_USER_READ] |-> rsp_tdata[31:0] == '0)
      else $error("read address set without a read");

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

endmodule

bind two_level_page_table_walker_core tlw_checker u_tlw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
